/* rtl/sfsd_pkg.sv */
// Shared types and constants for the sync-framed sensor frame decoder.
package sfsd_pkg;

   localparam int DEF_CHANNELS = 12;
   localparam int BYTE_W       = 8;
   localparam int COUNT_W      = 22;
   localparam int VAL_W        = 23;
   localparam int CHAN_W       = 4;

   localparam logic [BYTE_W-1:0]  SYNC_BYTE = 8'hFF;
   localparam logic [COUNT_W-1:0] SCALE_Q12 = 22'd33;

   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_CAPTURE = 1'b1;

   typedef enum logic [6:0] {
      ST_SYNC1 = 7'b0000001,
      ST_SYNC2 = 7'b0000010,
      ST_HIGH  = 7'b0000100,
      ST_LOW   = 7'b0001000,
      ST_SUB   = 7'b0010000,
      ST_PEAK  = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load_high;
      logic load_count;
      logic calc_val;
      logic upd_peak;
      logic emit_step;
      logic capture;
      logic clr_frame;
   } dp_cmd_type;

   typedef struct packed {
      logic sync_hit;
      logic idx_last;
      logic walk_last;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/sfsd_ctrl.sv */
// Controller: framing, sample sequencing and frame-end walk.
module sfsd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_cmd,
   output logic                   req_ready,
   output sfsd_pkg::dp_cmd_type   cmd_o,
   input  sfsd_pkg::dp_status_type st_i
);
   import sfsd_pkg::*;

   state_type state_ff, state_in;
   logic      cap_ff, cap_in;
   logic      acc_byte;

   assign req_ready = (state_ff == ST_SYNC1) || (state_ff == ST_SYNC2) ||
                      (state_ff == ST_HIGH)  || (state_ff == ST_LOW);
   assign acc_byte  = req_valid && req_ready && (req_cmd == CMD_BYTE);

   always_comb begin
      state_in = state_ff;
      cap_in   = cap_ff;
      cmd_o    = '0;
      unique case (state_ff)
         ST_SYNC1: begin
            if (acc_byte && st_i.sync_hit) state_in = ST_SYNC2;
         end
         ST_SYNC2: begin
            if (acc_byte) begin
               if (st_i.sync_hit) begin
                  state_in        = ST_HIGH;
                  cmd_o.clr_frame = 1'b1;
               end else begin
                  state_in = ST_SYNC1;
               end
            end
         end
         ST_HIGH: begin
            if (acc_byte) begin
               cmd_o.load_high = 1'b1;
               state_in        = ST_LOW;
            end
         end
         ST_LOW: begin
            if (acc_byte) begin
               cmd_o.load_count = 1'b1;
               state_in         = ST_SUB;
            end
         end
         ST_SUB: begin
            cmd_o.calc_val = 1'b1;
            state_in       = ST_PEAK;
         end
         ST_PEAK: begin
            cmd_o.upd_peak = 1'b1;
            state_in       = st_i.idx_last ? ST_EMIT : ST_HIGH;
         end
         ST_EMIT: begin
            if (st_i.out_free) begin
               cmd_o.emit_step = 1'b1;
               cmd_o.capture   = cap_ff;
               if (st_i.walk_last) begin
                  cmd_o.clr_frame = 1'b1;
                  cap_in          = 1'b0;
                  state_in        = ST_SYNC1;
               end
            end
         end
         default: state_in = ST_SYNC1;
      endcase
      if (req_valid && req_ready && (req_cmd == CMD_CAPTURE)) cap_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC1;
         cap_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         cap_ff   <= cap_in;
      end
   end

endmodule

/* rtl/sfsd_dp.sv */
// Datapath: sample scaling, offset stores, peak tracking and result register.
module sfsd_dp #(
   parameter int CHANNELS = sfsd_pkg::DEF_CHANNELS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sfsd_pkg::BYTE_W-1:0]       req_rx_byte,
   input  sfsd_pkg::dp_cmd_type              cmd_i,
   output sfsd_pkg::dp_status_type           st_o,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [sfsd_pkg::CHAN_W-1:0]       rsp_channel,
   output logic signed [sfsd_pkg::VAL_W-1:0] rsp_sample_value,
   output logic                              rsp_last,
   output logic [sfsd_pkg::COUNT_W-1:0]      rsp_peak_magnitude,
   output logic [sfsd_pkg::CHAN_W-1:0]       rsp_peak_channel
);
   import sfsd_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

   logic [BYTE_W-1:0]        high_ff;
   logic [COUNT_W-1:0]       count_ff;
   logic signed [VAL_W-1:0]  val_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [IDX_W-1:0]         walk_ff;
   logic [COUNT_W-1:0]       peak_ff;
   logic [IDX_W-1:0]         peak_ch_ff;
   logic signed [VAL_W-1:0]  sample_ff [CHANNELS];
   logic [COUNT_W-1:0]       offset_ff [CHANNELS];

   logic                     rsp_valid_ff;
   logic [CHAN_W-1:0]        rsp_channel_ff;
   logic signed [VAL_W-1:0]  rsp_value_ff;
   logic                     rsp_last_ff;
   logic [COUNT_W-1:0]       rsp_peak_ff;
   logic [CHAN_W-1:0]        rsp_peak_ch_ff;

   logic [IDX_W-1:0]         offs_addr;
   logic [COUNT_W-1:0]       offs_rd;
   logic signed [VAL_W-1:0]  walk_sample;
   logic [COUNT_W-1:0]       count_in;
   logic signed [VAL_W-1:0]  val_in;
   logic [VAL_W-1:0]         val_neg;
   logic [COUNT_W-1:0]       mag;
   logic [VAL_W-1:0]         cap_sum;

   assign offs_addr   = cmd_i.emit_step ? walk_ff : idx_ff;
   assign offs_rd     = offset_ff[offs_addr];
   assign walk_sample = sample_ff[walk_ff];
   assign count_in    = COUNT_W'({high_ff, req_rx_byte}) * SCALE_Q12;
   assign val_in      = signed'({1'b0, count_ff}) - signed'({1'b0, offs_rd});
   assign val_neg     = -val_ff;
   assign mag         = val_ff[VAL_W-1] ? val_neg[COUNT_W-1:0] : val_ff[COUNT_W-1:0];
   assign cap_sum     = walk_sample + signed'({1'b0, offs_rd});

   assign st_o.sync_hit  = (req_rx_byte == SYNC_BYTE);
   assign st_o.idx_last  = (idx_ff == IDX_LAST);
   assign st_o.walk_last = (walk_ff == IDX_LAST);
   assign st_o.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd_i.load_count) count_ff <= count_in;
      if (cmd_i.calc_val)   val_ff   <= val_in;
      if (cmd_i.upd_peak)   sample_ff[idx_ff] <= val_ff;
      if (cmd_i.emit_step) begin
         rsp_channel_ff <= CHAN_W'(walk_ff);
         rsp_value_ff   <= walk_sample;
         rsp_last_ff    <= (walk_ff == IDX_LAST);
         rsp_peak_ff    <= peak_ff;
         rsp_peak_ch_ff <= CHAN_W'(peak_ch_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff      <= '0;
         idx_ff       <= '0;
         walk_ff      <= '0;
         peak_ff      <= '0;
         peak_ch_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) offset_ff[i] <= '0;
      end else begin
         if (cmd_i.load_high) high_ff <= req_rx_byte;
         if (cmd_i.upd_peak) begin
            if (mag > peak_ff) begin
               peak_ff    <= mag;
               peak_ch_ff <= idx_ff;
            end
            idx_ff <= st_o.idx_last ? '0 : idx_ff + 1'b1;
         end
         if (cmd_i.emit_step) begin
            walk_ff <= st_o.walk_last ? '0 : walk_ff + 1'b1;
            if (cmd_i.capture) offset_ff[walk_ff] <= cap_sum[COUNT_W-1:0];
         end
         if (cmd_i.clr_frame) begin
            idx_ff     <= '0;
            peak_ff    <= '0;
            peak_ch_ff <= '0;
         end
         if (cmd_i.emit_step)  rsp_valid_ff <= 1'b1;
         else if (rsp_ready)   rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel        = rsp_channel_ff;
   assign rsp_sample_value   = rsp_value_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_peak_magnitude = rsp_peak_ff;
   assign rsp_peak_channel   = rsp_peak_ch_ff;

endmodule

/* rtl/sync_framed_sensor_frame_decoder_top.sv */
// Top level of the sync-framed sensor frame decoder.
//
//   channel | ports                                              | direction
//   req     | req_valid req_ready req_cmd req_rx_byte             | in
//   rsp     | rsp_valid rsp_ready rsp_channel rsp_sample_value    | out
//           | rsp_last rsp_peak_magnitude rsp_peak_channel        |
//
// Sync, high-byte and capture items need only their handshake; a low byte passes through
// three steps (scale, offset subtract, peak update) in the one shared datapath.
// The frame-end walk gives one result per cycle while rsp is not stalled, CHANNELS in all;
// no req item is taken during the walk.
// Synchronous reset clears framing, peak and offsets and sets a capture pending.
module sync_framed_sensor_frame_decoder_top #(
   parameter int CHANNELS = sfsd_pkg::DEF_CHANNELS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [sfsd_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sfsd_pkg::CHAN_W-1:0]       rsp_channel,
   output logic signed [sfsd_pkg::VAL_W-1:0] rsp_sample_value,
   output logic                              rsp_last,
   output logic [sfsd_pkg::COUNT_W-1:0]      rsp_peak_magnitude,
   output logic [sfsd_pkg::CHAN_W-1:0]       rsp_peak_channel
);
   import sfsd_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_st;

   sfsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .cmd_o     (dp_cmd),
      .st_i      (dp_st)
   );

   sfsd_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .cmd_i              (dp_cmd),
      .st_o               (dp_st),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_channel        (rsp_channel),
      .rsp_sample_value   (rsp_sample_value),
      .rsp_last           (rsp_last),
      .rsp_peak_magnitude (rsp_peak_magnitude),
      .rsp_peak_channel   (rsp_peak_channel)
   );

`ifndef SYNTHESIS
   // never overwrite a result still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit_step |-> dp_st.out_free)
      else $error("result register overwritten");

   // no item taken during the frame-end walk
   a_walk_blocks: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit_step |-> !req_ready)
      else $error("item accepted during walk");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({dp_cmd.load_high, dp_cmd.load_count, dp_cmd.calc_val,
                dp_cmd.upd_peak, dp_cmd.emit_step}))
      else $error("conflicting datapath commands");
`endif

endmodule

/* verif/tb_sync_framed_sensor_frame_decoder_top.sv */
// Self-checking testbench for the sync-framed sensor frame decoder top level.
`timescale 1ns / 1ps

import sfsd_pkg::*;

typedef struct packed {
   logic [CHAN_W-1:0]         channel;
   logic signed [VAL_W-1:0]   value;
   logic                      last;
   logic [COUNT_W-1:0]        peak;
   logic [CHAN_W-1:0]         peak_chan;
} frame_result_t;

typedef enum int {HUNT_FIRST, HUNT_SECOND, WANT_HIGH, WANT_LOW} frame_phase_e;

class frame_scoreboard;
   frame_phase_e            phase;
   logic [BYTE_W-1:0]       hi_byte;
   int unsigned             slot;
   logic signed [VAL_W-1:0] corrected [DEF_CHANNELS];
   logic [COUNT_W-1:0]      offsets [DEF_CHANNELS];
   logic [COUNT_W-1:0]      peak;
   logic [CHAN_W-1:0]       peak_chan;
   bit                      capture_armed;
   frame_result_t           due [$];
   int                      errors;

   function new();
      phase = HUNT_FIRST;
      hi_byte = '0;
      slot = 0;
      peak = '0;
      peak_chan = '0;
      capture_armed = 1;
      errors = 0;
      foreach (offsets[i]) begin
         offsets[i] = '0;
         corrected[i] = '0;
      end
   endfunction

   function int pending();
      return due.size();
   endfunction

   function void note_item(logic cmd, logic [BYTE_W-1:0] b);
      logic [COUNT_W-1:0]      count;
      logic signed [VAL_W-1:0] val;
      logic [COUNT_W-1:0]      mag;
      frame_result_t           r;
      if (cmd == CMD_CAPTURE) begin
         capture_armed = 1;
         return;
      end
      case (phase)
         HUNT_FIRST: begin
            if (b == SYNC_BYTE) phase = HUNT_SECOND;
         end
         HUNT_SECOND: begin
            if (b == SYNC_BYTE) begin
               phase = WANT_HIGH;
               slot = 0;
               peak = '0;
               peak_chan = '0;
            end else begin
               phase = HUNT_FIRST;
            end
         end
         WANT_HIGH: begin
            hi_byte = b;
            phase = WANT_LOW;
         end
         default: begin
            count = {hi_byte, b} * SCALE_Q12;
            val = $signed({1'b0, count}) - $signed({1'b0, offsets[slot]});
            corrected[slot] = val;
            mag = COUNT_W'((val < 0) ? -val : val);
            if (mag > peak) begin
               peak = mag;
               peak_chan = CHAN_W'(slot);
            end
            slot++;
            if (slot < DEF_CHANNELS) begin
               phase = WANT_HIGH;
            end else begin
               for (int i = 0; i < DEF_CHANNELS; i++) begin
                  r.channel = CHAN_W'(i);
                  r.value = corrected[i];
                  r.last = (i == DEF_CHANNELS - 1);
                  r.peak = peak;
                  r.peak_chan = peak_chan;
                  due.push_back(r);
               end
               if (capture_armed) begin
                  foreach (offsets[i])
                     offsets[i] = COUNT_W'(corrected[i] + $signed({1'b0, offsets[i]}));
                  capture_armed = 0;
               end
               slot = 0;
               peak = '0;
               peak_chan = '0;
               phase = HUNT_FIRST;
            end
         end
      endcase
   endfunction

   function void compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_result(frame_result_t got);
      frame_result_t want;
      if (due.size() == 0) begin
         $display("%0t: unexpected result, channel %0d value %0d", $time, got.channel,
                  $signed(got.value));
         errors++;
         return;
      end
      want = due.pop_front();
      compare_field("channel", want.channel, got.channel);
      compare_field("sample_value", $signed(want.value), $signed(got.value));
      compare_field("last", want.last, got.last);
      compare_field("peak_magnitude", want.peak, got.peak);
      compare_field("peak_channel", want.peak_chan, got.peak_chan);
   endfunction
endclass

module tb_sync_framed_sensor_frame_decoder_top;

   localparam int LIMIT = 200000;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_cmd;
   logic [BYTE_W-1:0]         req_rx_byte;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [CHAN_W-1:0]         rsp_channel;
   logic signed [VAL_W-1:0]   rsp_sample_value;
   logic                      rsp_last;
   logic [COUNT_W-1:0]        rsp_peak_magnitude;
   logic [CHAN_W-1:0]         rsp_peak_channel;

   frame_scoreboard sb;
   frame_result_t   seen;
   logic [15:0]     frame_raw [DEF_CHANNELS];
   int              sent_items;
   int              cycles;
   bit              calm;
   bit              squeeze_req;

   sync_framed_sensor_frame_decoder_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_channel        (rsp_channel),
      .rsp_sample_value   (rsp_sample_value),
      .rsp_last           (rsp_last),
      .rsp_peak_magnitude (rsp_peak_magnitude),
      .rsp_peak_channel   (rsp_peak_channel)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial cycles = 0;
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.channel = rsp_channel;
         seen.value = rsp_sample_value;
         seen.last = rsp_last;
         seen.peak = rsp_peak_magnitude;
         seen.peak_chan = rsp_peak_channel;
         sb.check_result(seen);
      end
   end

   // result side: random back-pressure plus one long hold-off
   initial begin
      int hold;
      bit squeezed;
      hold = 0;
      squeezed = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_req && !squeezed) begin
            squeezed = 1;
            hold = 400;
         end
         if (hold > 0) begin
            rsp_ready = 1'b0;
            hold--;
         end else begin
            rsp_ready = calm || ($urandom_range(99) >= 36);
         end
      end
   end

   task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b);
      int gap;
      gap = (!calm && $urandom_range(99) < 36) ? $urandom_range(1, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_rx_byte = b;
      do @(posedge clock); while (!req_ready);
      sb.note_item(cmd, b);
      sent_items++;
   endtask

   // two sync bytes, then the samples in frame_raw; optional capture item before one sample
   task automatic send_frame(input int capture_at);
      send_item(CMD_BYTE, SYNC_BYTE);
      send_item(CMD_BYTE, SYNC_BYTE);
      for (int i = 0; i < DEF_CHANNELS; i++) begin
         if (i == capture_at) send_item(CMD_CAPTURE, 8'($urandom_range(255)));
         send_item(CMD_BYTE, frame_raw[i][15:8]);
         send_item(CMD_BYTE, frame_raw[i][7:0]);
      end
   endtask

   initial begin
      int pick;
      int style;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_BYTE;
      req_rx_byte = '0;
      calm = 0;
      squeeze_req = 0;
      sent_items = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // broken sync, ignored byte on a capture item, repeated capture requests
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_BYTE, SYNC_BYTE);
      send_item(CMD_BYTE, 8'h7E);
      send_item(CMD_BYTE, 8'h7E);
      send_item(CMD_BYTE, SYNC_BYTE);
      send_item(CMD_CAPTURE, SYNC_BYTE);
      send_item(CMD_CAPTURE, 8'h00);
      send_item(CMD_BYTE, 8'h00);

      // first frame captures the offsets; tie on full scale goes to channel 0
      frame_raw = '{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00,
                    16'h0001, 16'hFFFE, 16'h0000, 16'hFFFF, 16'h1234, 16'h0000};
      send_frame(5);
      // inverted frame: both signed extremes
      frame_raw = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFF00, 16'h00FF,
                    16'hFFFE, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
      send_frame(-1);

      squeeze_req = 1;
      while (sent_items < 430) begin
         calm = (sent_items >= 230 && sent_items < 330);
         pick = $urandom_range(99);
         if (pick < 70) begin
            style = $urandom_range(2);
            // style 2 replays the previous frame's samples
            if (style != 2) begin
               for (int i = 0; i < DEF_CHANNELS; i++) begin
                  if (style == 0) frame_raw[i] = 16'($urandom_range(65535));
                  else
                     frame_raw[i] = ($urandom_range(2) == 0) ? 16'h0000 :
                                    ($urandom_range(1) == 0) ? 16'hFFFF :
                                    16'($urandom_range(65535));
               end
            end
            send_frame(($urandom_range(9) == 0) ? $urandom_range(DEF_CHANNELS - 1) : -1);
         end else if (pick < 80) begin
            send_item(CMD_CAPTURE, 8'($urandom_range(255)));
         end else if (pick < 90) begin
            send_item(CMD_BYTE, 8'($urandom_range(255)));
         end else begin
            send_item(CMD_BYTE, SYNC_BYTE);
            if ($urandom_range(1) == 1) send_item(CMD_CAPTURE, 8'($urandom_range(255)));
            send_item(CMD_BYTE, 8'($urandom_range(254)));
         end
      end
      calm = 0;

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
